/* hw/rtl/adls_pkg.sv */
// Shared constants, types and the control program of the level smoother.
`default_nettype none

package adls_pkg;

   localparam int NUM_BANDS  = 64;
   localparam int CHAN_COUNT = NUM_BANDS + 4;
   localparam int CHAN_W     = 7;
   localparam int BAND_W     = (NUM_BANDS > 1) ? $clog2(NUM_BANDS) : 1;

   localparam int RAW_W   = 32;
   localparam int GAIN_W  = 16;
   localparam int LEVEL_W = 24;
   localparam int GPROD_W = 32;
   localparam int PROD_W  = 63;
   localparam int ACC_W   = 40;
   localparam int WNEW_W  = 17;

   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;

   localparam logic [CSR_IDX_W-1:0] CSR_DECAY_INERTIA = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_VOLUME_GAIN   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_BASS_GAIN     = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_MID_GAIN      = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_TREBLE_GAIN   = 3'd4;

   localparam logic [LEVEL_W-1:0]  LEVEL_ONE     = 24'd8388608;
   localparam logic [LEVEL_W-1:0]  FLUSH_BELOW   = 24'd84;
   localparam logic [GAIN_W-1:0]   ATTACK_OLD_W  = 16'd9830;
   localparam logic [WNEW_W-1:0]   ATTACK_NEW_W  = 17'd55706;
   localparam logic [GAIN_W-1:0]   INERTIA_MAX   = 16'd64880;
   localparam logic [WNEW_W-1:0]   WEIGHT_ONE    = 17'h10000;
   localparam logic [GAIN_W-1:0]   INERTIA_RESET = 16'd55706;
   localparam logic [GAIN_W-1:0]   GAIN_UNITY    = 16'd4096;
   localparam logic [PROD_W-1:0]   TARGET_ROUND  = 63'h800000;
   localparam logic [ACC_W-1:0]    BLEND_ROUND   = 40'h8000;

   localparam logic REQ_SAMPLE   = 1'b0;
   localparam logic REQ_EQ_WRITE = 1'b1;

   localparam int STEP_W = 4;
   localparam logic [STEP_W-1:0] STEP_READ   = 4'd0;
   localparam logic [STEP_W-1:0] STEP_GAIN   = 4'd1;
   localparam logic [STEP_W-1:0] STEP_PROD   = 4'd2;
   localparam logic [STEP_W-1:0] STEP_TARGET = 4'd3;
   localparam logic [STEP_W-1:0] STEP_WEIGHT = 4'd4;
   localparam logic [STEP_W-1:0] STEP_MAC_LD = 4'd5;
   localparam logic [STEP_W-1:0] STEP_MAC_AD = 4'd6;
   localparam logic [STEP_W-1:0] STEP_FINISH = 4'd7;
   localparam logic [STEP_W-1:0] STEP_EQW    = 4'd8;
   localparam logic [STEP_W-1:0] STEP_DROP   = 4'd9;

   typedef enum logic [3:0] {
      OP_NONE,
      OP_READ,
      OP_GAIN,
      OP_PROD,
      OP_TARGET,
      OP_WEIGHT,
      OP_MAC_LOAD,
      OP_MAC_ADD,
      OP_FINISH,
      OP_EQ_WRITE
   } dp_op_type;

   typedef enum logic [1:0] {
      JC_NONE,
      JC_EQW,
      JC_DROP
   } jump_cond_type;

   typedef enum logic {
      SEQ_IDLE,
      SEQ_RUN
   } seq_state_type;

   typedef struct packed {
      dp_op_type          op;
      jump_cond_type      cond;
      logic [STEP_W-1:0]  target;
      logic               last;
   } ucode_word_type;

   typedef struct packed {
      logic       accept;
      dp_op_type  op;
   } ctrl_type;

   typedef struct packed {
      logic eq_write;
      logic drop;
      logic out_blocked;
   } status_type;

   typedef struct packed {
      logic [GAIN_W-1:0] decay_inertia;
      logic [GAIN_W-1:0] volume_gain;
      logic [GAIN_W-1:0] bass_gain;
      logic [GAIN_W-1:0] mid_gain;
      logic [GAIN_W-1:0] treble_gain;
   } cfg_type;

   function automatic ucode_word_type ucode_rom(input logic [STEP_W-1:0] step);
      ucode_word_type w;
      unique case (step)
         STEP_READ:   w = '{op: OP_READ,     cond: JC_EQW,  target: STEP_EQW,  last: 1'b0};
         STEP_GAIN:   w = '{op: OP_GAIN,     cond: JC_DROP, target: STEP_DROP, last: 1'b0};
         STEP_PROD:   w = '{op: OP_PROD,     cond: JC_NONE, target: STEP_READ, last: 1'b0};
         STEP_TARGET: w = '{op: OP_TARGET,   cond: JC_NONE, target: STEP_READ, last: 1'b0};
         STEP_WEIGHT: w = '{op: OP_WEIGHT,   cond: JC_NONE, target: STEP_READ, last: 1'b0};
         STEP_MAC_LD: w = '{op: OP_MAC_LOAD, cond: JC_NONE, target: STEP_READ, last: 1'b0};
         STEP_MAC_AD: w = '{op: OP_MAC_ADD,  cond: JC_NONE, target: STEP_READ, last: 1'b0};
         STEP_FINISH: w = '{op: OP_FINISH,   cond: JC_NONE, target: STEP_READ, last: 1'b1};
         STEP_EQW:    w = '{op: OP_EQ_WRITE, cond: JC_NONE, target: STEP_READ, last: 1'b1};
         default:     w = '{op: OP_NONE,     cond: JC_NONE, target: STEP_READ, last: 1'b1};
      endcase
      return w;
   endfunction

endpackage

`default_nettype wire

/* hw/rtl/adls_req_if.sv */
// Request channel interface carrying one level sample or EQ write word.
`default_nettype none

interface adls_req_if;
   logic                              valid;
   logic                              ready;
   logic                              req_type;
   logic [adls_pkg::CHAN_W-1:0]       channel;
   logic signed [adls_pkg::RAW_W-1:0] raw_level;
   logic [adls_pkg::GAIN_W-1:0]       eq_gain;

   modport source (output valid, output req_type, output channel, output raw_level,
                   output eq_gain, input ready);
   modport sink (input valid, input req_type, input channel, input raw_level,
                 input eq_gain, output ready);
endinterface

`default_nettype wire

/* hw/rtl/adls_rsp_if.sv */
// Response channel interface carrying one smoothed level word.
`default_nettype none

interface adls_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [adls_pkg::CHAN_W-1:0]  out_channel;
   logic [adls_pkg::LEVEL_W-1:0] smoothed_level;

   modport source (output valid, output out_channel, output smoothed_level, input ready);
   modport sink (input valid, input out_channel, input smoothed_level, output ready);
endinterface

`default_nettype wire

/* hw/rtl/adls_seq.sv */
// Microcode sequencer: step counter, control ROM lookup and conditional jumps.
`default_nettype none

module adls_seq (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_ready,
   input  wire adls_pkg::status_type status,
   output adls_pkg::ctrl_type        ctrl
);

   adls_pkg::seq_state_type         state_ff, state_in;
   logic [adls_pkg::STEP_W-1:0]     step_ff, step_in;
   adls_pkg::ucode_word_type        word;
   logic                            stall;
   logic                            take_jump;

   assign word  = adls_pkg::ucode_rom(step_ff);
   assign stall = (word.op == adls_pkg::OP_FINISH) && status.out_blocked;

   always_comb begin
      unique case (word.cond)
         adls_pkg::JC_NONE: take_jump = 1'b0;
         adls_pkg::JC_EQW:  take_jump = status.eq_write;
         adls_pkg::JC_DROP: take_jump = status.drop;
         default:           take_jump = 1'b0;
      endcase
   end

   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      unique case (state_ff)
         adls_pkg::SEQ_IDLE: begin
            if (req_valid) begin
               state_in = adls_pkg::SEQ_RUN;
               step_in  = adls_pkg::STEP_READ;
            end
         end
         adls_pkg::SEQ_RUN: begin
            if (!stall) begin
               if (word.last) begin
                  state_in = adls_pkg::SEQ_IDLE;
               end else if (take_jump) begin
                  step_in = word.target;
               end else begin
                  step_in = step_ff + 1'b1;
               end
            end
         end
         default: state_in = adls_pkg::SEQ_IDLE;
      endcase
   end

   always_comb begin
      req_ready   = (state_ff == adls_pkg::SEQ_IDLE);
      ctrl.accept = (state_ff == adls_pkg::SEQ_IDLE) && req_valid;
      ctrl.op     = ((state_ff == adls_pkg::SEQ_RUN) && !stall) ? word.op : adls_pkg::OP_NONE;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= adls_pkg::SEQ_IDLE;
         step_ff  <= adls_pkg::STEP_READ;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
   end

endmodule

`default_nettype wire

/* hw/rtl/adls_dp.sv */
// Datapath: level and EQ stores, one operation per step, staged products and result register.
`default_nettype none

module adls_dp (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire adls_pkg::ctrl_type                ctrl,
   input  wire adls_pkg::cfg_type                 cfg,
   input  wire logic                              req_type,
   input  wire logic [adls_pkg::CHAN_W-1:0]       channel,
   input  wire logic signed [adls_pkg::RAW_W-1:0] raw_level,
   input  wire logic [adls_pkg::GAIN_W-1:0]       eq_gain,
   input  wire logic                              rsp_ready,
   output logic                                   rsp_valid,
   output logic [adls_pkg::CHAN_W-1:0]            out_channel,
   output logic [adls_pkg::LEVEL_W-1:0]           smoothed_level,
   output adls_pkg::status_type                   status
);

   logic [adls_pkg::LEVEL_W-1:0] level_mem [adls_pkg::CHAN_COUNT];
   logic [adls_pkg::GAIN_W-1:0]  eq_mem [adls_pkg::NUM_BANDS];
   logic [adls_pkg::CHAN_COUNT-1:0] level_vld_ff;
   logic [adls_pkg::NUM_BANDS-1:0]  eq_vld_ff;

   logic                                 type_ff;
   logic [adls_pkg::CHAN_W-1:0]          chan_ff;
   logic signed [adls_pkg::RAW_W-1:0]    raw_ff;
   logic [adls_pkg::GAIN_W-1:0]          eqg_ff;

   logic [adls_pkg::LEVEL_W-1:0]  lvl_rd_ff;
   logic                          lvl_rd_vld_ff;
   logic [adls_pkg::GAIN_W-1:0]   eq_rd_ff;
   logic                          eq_rd_vld_ff;
   logic [adls_pkg::GPROD_W-1:0]  gain_ff;
   logic [adls_pkg::PROD_W-1:0]   prod_ff;
   logic [adls_pkg::LEVEL_W-1:0]  target_ff;
   logic [adls_pkg::LEVEL_W-1:0]  cur_ff;
   logic [adls_pkg::GAIN_W-1:0]   w_old_ff;
   logic [adls_pkg::WNEW_W-1:0]   w_new_ff;
   logic [adls_pkg::ACC_W-1:0]    acc_ff;

   logic [adls_pkg::CHAN_W-1:0]   out_chan_ff;
   logic [adls_pkg::LEVEL_W-1:0]  out_level_ff;
   logic                          out_valid_ff;

   logic                          chan_ok;
   logic                          is_band;
   logic                          band_ok;
   logic [adls_pkg::CHAN_W-1:0]   band_sub;
   logic [adls_pkg::BAND_W-1:0]   band_idx;
   logic [adls_pkg::BAND_W-1:0]   eqw_idx;
   logic [adls_pkg::GAIN_W-1:0]   eq_eff;
   logic [adls_pkg::GAIN_W-1:0]   chan_gain;
   logic [adls_pkg::GPROD_W-1:0]  gain_next;
   logic [adls_pkg::PROD_W-1:0]   tgt_sum;
   logic [adls_pkg::PROD_W-25:0]  tgt_q;
   logic [adls_pkg::LEVEL_W-1:0]  tgt_sat;
   logic [adls_pkg::LEVEL_W-1:0]  level_cur;
   logic                          attack;
   logic [adls_pkg::GAIN_W-1:0]   inertia;
   logic [adls_pkg::ACC_W-1:0]    acc_rnd;
   logic [adls_pkg::LEVEL_W-1:0]  nv_raw;
   logic [adls_pkg::LEVEL_W-1:0]  nv;
   logic                          finish_fire;
   logic                          eqw_fire;

   assign chan_ok  = chan_ff < adls_pkg::CHAN_W'(adls_pkg::CHAN_COUNT);
   assign is_band  = chan_ff >= adls_pkg::CHAN_W'(4);
   assign band_ok  = chan_ff < adls_pkg::CHAN_W'(adls_pkg::NUM_BANDS);
   assign band_sub = chan_ff - adls_pkg::CHAN_W'(4);
   assign band_idx = band_sub[adls_pkg::BAND_W-1:0];
   assign eqw_idx  = chan_ff[adls_pkg::BAND_W-1:0];

   assign eq_eff    = eq_rd_vld_ff ? eq_rd_ff : '0;
   assign level_cur = lvl_rd_vld_ff ? lvl_rd_ff : '0;

   always_comb begin
      unique case (chan_ff[1:0])
         2'd0:    chan_gain = cfg.volume_gain;
         2'd1:    chan_gain = cfg.bass_gain;
         2'd2:    chan_gain = cfg.mid_gain;
         default: chan_gain = cfg.treble_gain;
      endcase
   end

   // Channel gains are lifted to Q8.24 so that both kinds share one rounding step.
   assign gain_next = is_band ? adls_pkg::GPROD_W'(cfg.volume_gain) *
                                adls_pkg::GPROD_W'(eq_eff)
                              : {4'b0, chan_gain, 12'b0};

   assign tgt_sum = prod_ff + adls_pkg::TARGET_ROUND;
   assign tgt_q   = tgt_sum[adls_pkg::PROD_W-1:24];
   assign tgt_sat = raw_ff[adls_pkg::RAW_W-1] ? '0
                  : (tgt_q > (adls_pkg::PROD_W-24)'(adls_pkg::LEVEL_ONE)) ? adls_pkg::LEVEL_ONE
                  : tgt_q[adls_pkg::LEVEL_W-1:0];

   assign attack  = target_ff > level_cur;
   assign inertia = (cfg.decay_inertia > adls_pkg::INERTIA_MAX) ? adls_pkg::INERTIA_MAX
                                                                : cfg.decay_inertia;

   assign acc_rnd = acc_ff + adls_pkg::BLEND_ROUND;
   assign nv_raw  = acc_rnd[adls_pkg::ACC_W-1:16];
   assign nv      = (nv_raw < adls_pkg::FLUSH_BELOW) ? '0 : nv_raw;

   assign finish_fire = (ctrl.op == adls_pkg::OP_FINISH);
   assign eqw_fire    = (ctrl.op == adls_pkg::OP_EQ_WRITE) && band_ok;

   always_ff @(posedge clock) begin
      if (ctrl.accept) begin
         type_ff <= req_type;
         chan_ff <= channel;
         raw_ff  <= raw_level;
         eqg_ff  <= eq_gain;
      end
      unique case (ctrl.op)
         adls_pkg::OP_READ: begin
            if (chan_ok) begin
               lvl_rd_ff     <= level_mem[chan_ff];
               lvl_rd_vld_ff <= level_vld_ff[chan_ff];
            end
            if (chan_ok && is_band) begin
               eq_rd_ff     <= eq_mem[band_idx];
               eq_rd_vld_ff <= eq_vld_ff[band_idx];
            end
         end
         adls_pkg::OP_GAIN: gain_ff <= gain_next;
         adls_pkg::OP_PROD: begin
            prod_ff <= adls_pkg::PROD_W'(raw_ff[adls_pkg::RAW_W-2:0]) *
                       adls_pkg::PROD_W'(gain_ff);
         end
         adls_pkg::OP_TARGET: target_ff <= tgt_sat;
         adls_pkg::OP_WEIGHT: begin
            cur_ff   <= level_cur;
            w_old_ff <= attack ? adls_pkg::ATTACK_OLD_W : inertia;
            w_new_ff <= attack ? adls_pkg::ATTACK_NEW_W
                               : adls_pkg::WEIGHT_ONE - adls_pkg::WNEW_W'(inertia);
         end
         adls_pkg::OP_MAC_LOAD: begin
            acc_ff <= adls_pkg::ACC_W'(cur_ff) * adls_pkg::ACC_W'(w_old_ff);
         end
         adls_pkg::OP_MAC_ADD: begin
            acc_ff <= acc_ff + adls_pkg::ACC_W'(adls_pkg::ACC_W'(target_ff) *
                                                adls_pkg::ACC_W'(w_new_ff));
         end
         adls_pkg::OP_FINISH: begin
            level_mem[chan_ff] <= nv;
            out_chan_ff        <= chan_ff;
            out_level_ff       <= nv;
         end
         adls_pkg::OP_EQ_WRITE: begin
            if (band_ok) begin
               eq_mem[eqw_idx] <= eqg_ff;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         level_vld_ff <= '0;
         eq_vld_ff    <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         if (finish_fire) begin
            level_vld_ff[chan_ff] <= 1'b1;
         end
         if (eqw_fire) begin
            eq_vld_ff[eqw_idx] <= 1'b1;
         end
         if (finish_fire) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid      = out_valid_ff;
   assign out_channel    = out_chan_ff;
   assign smoothed_level = out_level_ff;

   assign status.eq_write    = (type_ff == adls_pkg::REQ_EQ_WRITE);
   assign status.drop        = !chan_ok;
   assign status.out_blocked = out_valid_ff && !rsp_ready;

endmodule

`default_nettype wire

/* hw/rtl/attack_decay_level_smoother_unit.sv */
// Top level of the attack/decay level smoother with its control registers.
// A level sample runs the ROM steps read, gain, product, target, weight, MAC load, MAC add and
// finish, one datapath operation per step; finish stalls while the last result is not taken.
// An EQ write runs read and EQ write, a dropped sample read and gain; one request at a time.
// Reset is synchronous and active high; it restores the control registers and marks
// both stores empty at once, so levels and EQ entries read as zero; there is no clearing pass.
`default_nettype none

module attack_decay_level_smoother_unit (
   input  wire logic                               clock,
   input  wire logic                               reset,
   adls_req_if.sink                                req_chan,
   adls_rsp_if.source                              rsp_chan,
   input  wire logic                               csr_we,
   input  wire logic [adls_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire logic [adls_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   adls_pkg::cfg_type    cfg_ff;
   adls_pkg::ctrl_type   ctrl;
   adls_pkg::status_type status;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.decay_inertia <= adls_pkg::INERTIA_RESET;
         cfg_ff.volume_gain   <= adls_pkg::GAIN_UNITY;
         cfg_ff.bass_gain     <= adls_pkg::GAIN_UNITY;
         cfg_ff.mid_gain      <= adls_pkg::GAIN_UNITY;
         cfg_ff.treble_gain   <= adls_pkg::GAIN_UNITY;
      end else if (csr_we) begin
         unique case (csr_index)
            adls_pkg::CSR_DECAY_INERTIA: cfg_ff.decay_inertia <= csr_wdata;
            adls_pkg::CSR_VOLUME_GAIN:   cfg_ff.volume_gain   <= csr_wdata;
            adls_pkg::CSR_BASS_GAIN:     cfg_ff.bass_gain     <= csr_wdata;
            adls_pkg::CSR_MID_GAIN:      cfg_ff.mid_gain      <= csr_wdata;
            adls_pkg::CSR_TREBLE_GAIN:   cfg_ff.treble_gain   <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   adls_seq u_seq (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .status    (status),
      .ctrl      (ctrl)
   );

   adls_dp u_dp (
      .clock          (clock),
      .reset          (reset),
      .ctrl           (ctrl),
      .cfg            (cfg_ff),
      .req_type       (req_chan.req_type),
      .channel        (req_chan.channel),
      .raw_level      (req_chan.raw_level),
      .eq_gain        (req_chan.eq_gain),
      .rsp_ready      (rsp_chan.ready),
      .rsp_valid      (rsp_chan.valid),
      .out_channel    (rsp_chan.out_channel),
      .smoothed_level (rsp_chan.smoothed_level),
      .status         (status)
   );

   a_level_in_range: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |-> rsp_chan.smoothed_level <= adls_pkg::LEVEL_ONE)
      else $error("smoothed level above full scale");

   a_flush_small: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |-> (rsp_chan.smoothed_level == '0 ||
                          rsp_chan.smoothed_level >= adls_pkg::FLUSH_BELOW))
      else $error("small level not flushed to zero");

   a_channel_in_range: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |->
         rsp_chan.out_channel < adls_pkg::CHAN_W'(adls_pkg::CHAN_COUNT))
      else $error("result for a channel out of range");

   a_no_result_from_idle: assert property (@(posedge clock) disable iff (reset)
      req_chan.ready |=> !$rose(rsp_chan.valid))
      else $error("result word appeared without a running sequence");

endmodule

`default_nettype wire

/* tb/tb_attack_decay_level_smoother_unit.sv */
// Self-checking testbench for the level smoother: a directed table, then random traffic.
`timescale 1ns / 100ps

module tb_attack_decay_level_smoother_unit;

   localparam logic [adls_pkg::CHAN_W-1:0] CH_VOLUME  = 7'd0;
   localparam logic [adls_pkg::CHAN_W-1:0] CH_BASS    = 7'd1;
   localparam logic [adls_pkg::CHAN_W-1:0] CH_MID     = 7'd2;
   localparam logic [adls_pkg::CHAN_W-1:0] FIRST_BAND = 7'd4;

   localparam logic [adls_pkg::CSR_IDX_W-1:0] CSR_SPARE = 3'd7;

   localparam logic CHECK_MODEL = 1'b0;
   localparam logic CHECK_TYPED = 1'b1;

   localparam int RAND_PHASES = 7;
   localparam int PHASE_WORDS = 220;
   localparam int SETTLE      = 12;

   typedef struct packed {
      logic                         kind;
      logic [adls_pkg::CHAN_W-1:0]  chan;
      logic [adls_pkg::RAW_W-1:0]   raw;
      logic [adls_pkg::GAIN_W-1:0]  eq;
      logic                         check;
      logic [adls_pkg::LEVEL_W-1:0] level;
   } stim_row_type;

   typedef struct packed {
      logic [adls_pkg::CHAN_W-1:0]  chan;
      logic [adls_pkg::LEVEL_W-1:0] level;
   } level_word_type;

   localparam int DIR_ROWS = 24;
   localparam stim_row_type DIRECTED [0:DIR_ROWS-1] = '{
      '{adls_pkg::REQ_SAMPLE,   7'd0,   32'h0000_0000, 16'h0000, CHECK_TYPED, 24'd0},
      '{adls_pkg::REQ_SAMPLE,   7'd4,   32'h7FFF_FFFF, 16'hFFFF, CHECK_TYPED, 24'd0},
      '{adls_pkg::REQ_SAMPLE,   7'd67,  32'h0080_0000, 16'h0000, CHECK_TYPED, 24'd0},
      '{adls_pkg::REQ_SAMPLE,   7'd0,   32'h7FFF_FFFF, 16'h0000, CHECK_TYPED, 24'd7130368},
      '{adls_pkg::REQ_SAMPLE,   7'd0,   32'h8000_0000, 16'h0000, CHECK_MODEL, 24'd0},
      '{adls_pkg::REQ_SAMPLE,   7'd1,   32'h0080_0000, 16'h0000, CHECK_TYPED, 24'd7130368},
      '{adls_pkg::REQ_SAMPLE,   7'd2,   32'h0080_0000, 16'h0000, CHECK_TYPED, 24'd7130368},
      '{adls_pkg::REQ_SAMPLE,   7'd3,   32'h0080_0000, 16'h0000, CHECK_TYPED, 24'd7130368},
      '{adls_pkg::REQ_SAMPLE,   7'd3,   32'hFFFF_FFFF, 16'h0000, CHECK_MODEL, 24'd0},
      '{adls_pkg::REQ_SAMPLE,   7'd68,  32'h0080_0000, 16'h0000, CHECK_MODEL, 24'd0},
      '{adls_pkg::REQ_SAMPLE,   7'd127, 32'h7FFF_FFFF, 16'hFFFF, CHECK_MODEL, 24'd0},
      '{adls_pkg::REQ_EQ_WRITE, 7'd0,   32'h0000_0000, 16'hFFFF, CHECK_MODEL, 24'd0},
      '{adls_pkg::REQ_EQ_WRITE, 7'd63,  32'hFFFF_FFFF, 16'h1000, CHECK_MODEL, 24'd0},
      '{adls_pkg::REQ_EQ_WRITE, 7'd64,  32'h0000_0000, 16'hFFFF, CHECK_MODEL, 24'd0},
      '{adls_pkg::REQ_EQ_WRITE, 7'd127, 32'h0000_0000, 16'h1000, CHECK_MODEL, 24'd0},
      '{adls_pkg::REQ_EQ_WRITE, 7'd2,   32'h0000_0000, 16'h1000, CHECK_MODEL, 24'd0},
      '{adls_pkg::REQ_SAMPLE,   7'd4,   32'h7FFF_FFFF, 16'h0000, CHECK_TYPED, 24'd7130368},
      '{adls_pkg::REQ_SAMPLE,   7'd67,  32'h0040_0000, 16'h0000, CHECK_MODEL, 24'd0},
      '{adls_pkg::REQ_SAMPLE,   7'd6,   32'd90,        16'h0000, CHECK_TYPED, 24'd0},
      '{adls_pkg::REQ_SAMPLE,   7'd6,   32'd100,       16'h0000, CHECK_MODEL, 24'd0},
      '{adls_pkg::REQ_SAMPLE,   7'd6,   32'd0,         16'h0000, CHECK_MODEL, 24'd0},
      '{adls_pkg::REQ_SAMPLE,   7'd0,   32'd0,         16'h0000, CHECK_MODEL, 24'd0},
      '{adls_pkg::REQ_SAMPLE,   7'd5,   32'h7FFF_FFFF, 16'h0000, CHECK_TYPED, 24'd0},
      '{adls_pkg::REQ_SAMPLE,   7'd64,  32'h0080_0000, 16'h0000, CHECK_TYPED, 24'd0}
   };

   logic                            clock;
   logic                            reset;
   logic                            csr_we;
   logic [adls_pkg::CSR_IDX_W-1:0]  csr_index;
   logic [adls_pkg::CSR_DATA_W-1:0] csr_wdata;

   adls_req_if req_chan ();
   adls_rsp_if rsp_chan ();

   attack_decay_level_smoother_unit uut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   level_word_type               pending_levels [$];
   logic [adls_pkg::LEVEL_W-1:0] level_mem [0:adls_pkg::CHAN_COUNT-1];
   logic [adls_pkg::GAIN_W-1:0]  eq_mem [0:adls_pkg::NUM_BANDS-1];
   adls_pkg::cfg_type            cfg_now;
   int                           fails = 0;
   int                           burst_left = 0;

   function automatic logic [adls_pkg::LEVEL_W-1:0] smooth_level(
         input logic [adls_pkg::CHAN_W-1:0] ch, input logic [adls_pkg::RAW_W-1:0] raw);
      logic [63:0]                  gain;
      logic [63:0]                  tgt;
      logic [63:0]                  acc;
      logic [adls_pkg::GAIN_W-1:0]  inertia;
      logic [adls_pkg::LEVEL_W-1:0] cur;
      logic [adls_pkg::LEVEL_W-1:0] nv;
      logic [adls_pkg::CHAN_W-1:0]  band;
      cur = level_mem[ch];
      band = ch - FIRST_BAND;
      if (raw[adls_pkg::RAW_W-1]) begin
         tgt = 64'd0;
      end else if (ch < FIRST_BAND) begin
         gain = (ch == CH_VOLUME) ? 64'(cfg_now.volume_gain)
              : (ch == CH_BASS)   ? 64'(cfg_now.bass_gain)
              : (ch == CH_MID)    ? 64'(cfg_now.mid_gain) : 64'(cfg_now.treble_gain);
         tgt = (64'(raw) * gain + 64'd2048) >> 12;
      end else begin
         gain = 64'(cfg_now.volume_gain) * 64'(eq_mem[band[adls_pkg::BAND_W-1:0]]);
         tgt = (64'(raw) * gain + 64'h80_0000) >> 24;
      end
      if (tgt > 64'(adls_pkg::LEVEL_ONE)) tgt = 64'(adls_pkg::LEVEL_ONE);
      if (tgt > 64'(cur)) begin
         acc = 64'(cur) * 64'(adls_pkg::ATTACK_OLD_W) + tgt * 64'(adls_pkg::ATTACK_NEW_W);
      end else begin
         inertia = (cfg_now.decay_inertia > adls_pkg::INERTIA_MAX) ? adls_pkg::INERTIA_MAX
                                                                   : cfg_now.decay_inertia;
         acc = 64'(cur) * 64'(inertia) + tgt * (64'd65536 - 64'(inertia));
      end
      acc = (acc + 64'd32768) >> 16;
      nv = acc[adls_pkg::LEVEL_W-1:0];
      if (nv < adls_pkg::FLUSH_BELOW) nv = '0;
      return nv;
   endfunction

   task automatic accept_word(input stim_row_type w);
      logic [adls_pkg::LEVEL_W-1:0] nv;
      if (w.kind == adls_pkg::REQ_EQ_WRITE) begin
         if (w.chan < adls_pkg::NUM_BANDS) eq_mem[w.chan[adls_pkg::BAND_W-1:0]] = w.eq;
      end else if (w.chan < adls_pkg::CHAN_COUNT) begin
         nv = smooth_level(w.chan, w.raw);
         level_mem[w.chan] = nv;
         pending_levels.push_back('{chan: w.chan,
                                    level: (w.check == CHECK_TYPED) ? w.level : nv});
      end
   endtask

   function automatic stim_row_type random_word();
      stim_row_type w;
      w = '0;
      w.check = CHECK_MODEL;
      w.raw = $urandom;
      w.eq = 16'($urandom);
      if ($urandom_range(0, 6) == 0) begin
         w.kind = adls_pkg::REQ_EQ_WRITE;
         w.chan = ($urandom_range(0, 7) == 0) ? 7'($urandom)
                                              : 7'($urandom_range(0, adls_pkg::NUM_BANDS - 1));
         case ($urandom_range(0, 5))
            0: begin
               w.eq = '0;
            end
            1: begin
               w.eq = '1;
            end
            2, 3: begin
               w.eq = 16'($urandom_range(0, 8192));
            end
            default: begin
            end
         endcase
      end else begin
         w.kind = adls_pkg::REQ_SAMPLE;
         case ($urandom_range(0, 15))
            0: begin
               w.chan = 7'($urandom_range(adls_pkg::CHAN_COUNT, 127));
            end
            1, 2, 3, 4: begin
               w.chan = 7'($urandom_range(0, FIRST_BAND - 1));
            end
            default: begin
               w.chan = 7'($urandom_range(FIRST_BAND, adls_pkg::CHAN_COUNT - 1));
            end
         endcase
         case ($urandom_range(0, 7))
            0: begin
            end
            1: begin
               w.raw[adls_pkg::RAW_W-1] = 1'b1;
            end
            2: begin
               w.raw = $urandom_range(0, 300);
            end
            3, 4, 5: begin
               w.raw = $urandom_range(0, 32'h0100_0000);
            end
            6: begin
               w.raw = $urandom_range(32'h007F_FF00, 32'h0080_0100);
            end
            default: begin
               w.raw = '0;
            end
         endcase
      end
      return w;
   endfunction

   // Called at a falling edge; returns at the falling edge after the word is taken.
   task automatic send_word(input stim_row_type w);
      if (burst_left == 0) begin
         req_chan.valid <= 1'b0;
         repeat ($urandom_range(1, 9)) @(negedge clock);
         burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 100)
                                                  : $urandom_range(1, 12);
      end
      burst_left--;
      req_chan.valid     <= 1'b1;
      req_chan.req_type  <= w.kind;
      req_chan.channel   <= w.chan;
      req_chan.raw_level <= w.raw;
      req_chan.eq_gain   <= w.eq;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      accept_word(w);
      @(negedge clock);
   endtask

   task automatic drain_results();
      req_chan.valid <= 1'b0;
      do begin
         @(negedge clock);
      end while (pending_levels.size() != 0);
   endtask

   task automatic write_reg(input logic [adls_pkg::CSR_IDX_W-1:0] idx,
                            input logic [adls_pkg::CSR_DATA_W-1:0] val);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(negedge clock);
      case (idx)
         adls_pkg::CSR_DECAY_INERTIA: begin
            cfg_now.decay_inertia = val;
         end
         adls_pkg::CSR_VOLUME_GAIN: begin
            cfg_now.volume_gain = val;
         end
         adls_pkg::CSR_BASS_GAIN: begin
            cfg_now.bass_gain = val;
         end
         adls_pkg::CSR_MID_GAIN: begin
            cfg_now.mid_gain = val;
         end
         adls_pkg::CSR_TREBLE_GAIN: begin
            cfg_now.treble_gain = val;
         end
         default: begin
         end
      endcase
   endtask

   task automatic set_regs(input logic [adls_pkg::GAIN_W-1:0] decay,
                           input logic [adls_pkg::GAIN_W-1:0] vol,
                           input logic [adls_pkg::GAIN_W-1:0] bass,
                           input logic [adls_pkg::GAIN_W-1:0] mid,
                           input logic [adls_pkg::GAIN_W-1:0] treble);
      write_reg(adls_pkg::CSR_DECAY_INERTIA, decay);
      write_reg(adls_pkg::CSR_VOLUME_GAIN, vol);
      write_reg(adls_pkg::CSR_BASS_GAIN, bass);
      write_reg(adls_pkg::CSR_MID_GAIN, mid);
      write_reg(adls_pkg::CSR_TREBLE_GAIN, treble);
      write_reg(CSR_SPARE, 16'($urandom));
      csr_we <= 1'b0;
   endtask

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("attack_decay_level_smoother_unit: mismatch");
      $finish;
   end

   initial begin
      logic [15:0] stall_bits;
      int          stall_left;
      stall_bits = '1;
      stall_left = 0;
      rsp_chan.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (stall_left == 0) begin
            stall_left = $urandom_range(16, 160);
            stall_bits = ($urandom_range(0, 3) == 0) ? 16'hFFFF : (16'($urandom) | 16'h0001);
         end
         stall_left--;
         rsp_chan.ready <= stall_bits[0];
         stall_bits = {stall_bits[0], stall_bits[15:1]};
      end
   end

   always @(posedge clock) begin
      level_word_type want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (pending_levels.size() == 0) begin
            $display("%0t: ERROR unexpected word, channel %0d level %0d", $time,
                     rsp_chan.out_channel, rsp_chan.smoothed_level);
            fails++;
         end else begin
            want = pending_levels.pop_front();
            if (rsp_chan.out_channel !== want.chan) begin
               $display("%0t: ERROR out_channel expected %0d actual %0d", $time,
                        want.chan, rsp_chan.out_channel);
               fails++;
            end
            if (rsp_chan.smoothed_level !== want.level) begin
               $display("%0t: ERROR smoothed_level on channel %0d expected %0d actual %0d",
                        $time, want.chan, want.level, rsp_chan.smoothed_level);
               fails++;
            end
         end
      end
   end

   initial begin
      reset              = 1'b1;
      csr_we             = 1'b0;
      csr_index          = '0;
      csr_wdata          = '0;
      req_chan.valid     = 1'b0;
      req_chan.req_type  = adls_pkg::REQ_SAMPLE;
      req_chan.channel   = '0;
      req_chan.raw_level = '0;
      req_chan.eq_gain   = '0;
      for (int i = 0; i < adls_pkg::CHAN_COUNT; i++) level_mem[i] = '0;
      for (int i = 0; i < adls_pkg::NUM_BANDS; i++) eq_mem[i] = '0;
      cfg_now = '{decay_inertia: adls_pkg::INERTIA_RESET, volume_gain: adls_pkg::GAIN_UNITY,
                  bass_gain: adls_pkg::GAIN_UNITY, mid_gain: adls_pkg::GAIN_UNITY,
                  treble_gain: adls_pkg::GAIN_UNITY};
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      for (int i = 0; i < DIR_ROWS; i++) send_word(DIRECTED[i]);

      for (int p = 0; p < RAND_PHASES; p++) begin
         drain_results();
         repeat (SETTLE) @(negedge clock);
         case (p)
            0: begin
               set_regs(adls_pkg::INERTIA_MAX, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
            end
            1: begin
               set_regs(16'h0000, 16'h0000, 16'hFFFF, 16'h0000, 16'h0001);
            end
            2: begin
               set_regs(16'hFFFF, adls_pkg::GAIN_UNITY, adls_pkg::GAIN_UNITY,
                        adls_pkg::GAIN_UNITY, adls_pkg::GAIN_UNITY);
            end
            default: begin
               set_regs(16'($urandom), 16'($urandom_range(0, 12288)),
                        16'($urandom_range(0, 12288)), 16'($urandom_range(0, 12288)),
                        16'($urandom_range(0, 12288)));
            end
         endcase
         for (int k = 0; k < PHASE_WORDS; k++) begin
            if (k == PHASE_WORDS / 2) drain_results();
            send_word(random_word());
         end
      end

      drain_results();
      repeat (20) @(posedge clock);
      if (fails == 0) begin
         $display("attack_decay_level_smoother_unit: match");
      end else begin
         $display("attack_decay_level_smoother_unit: mismatch");
      end
      $finish;
   end

endmodule
